/* hw/rtl/pkwrg_pkg.sv */
package pkwrg_pkg;

  localparam int KEY_W  = 64;
  localparam int CNT_W  = 17;
  localparam int MIN_W  = 27;
  localparam int STAT_W = 32;
  localparam int SEC_W  = 32;
  localparam int CMD_W  = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADMIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL    = 2'd2;

  // Register indexes
  localparam logic REG_GLOBAL_LIMIT  = 1'b0;
  localparam logic REG_PER_KEY_LIMIT = 1'b1;

  // Limits
  localparam logic [CNT_W-1:0] GLOBAL_DEFAULT  = 17'd120;
  localparam logic [CNT_W-1:0] PER_KEY_DEFAULT = 17'd30;
  localparam logic [CNT_W-1:0] LIMIT_MAX       = 17'd100000;

  // Seconds to minutes: exact for every 32-bit value as (x * magic) >> 37
  localparam logic [SEC_W-1:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int               DIV60_SHIFT = 37;

  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             free_seen;
    logic [CNT_W-1:0] count;
  } tok_t;

  // Broadcast command to all cells
  typedef struct packed {
    logic             clear;
    logic             write;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (v == STAT_MAX) ? v : v + STAT_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] dflt);
    eff_limit = (v == '0 || v > LIMIT_MAX) ? dflt : v;
  endfunction

endpackage

/* hw/rtl/pkwrg_cell.sv */
module pkwrg_cell
  import pkwrg_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic             sel,
  input  logic [KEY_W-1:0] search_key,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] idx_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] idx_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] count_r;
  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Entry valid: clear on rollover, set on claim
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.clear) begin
      valid_r <= 1'b0;
    end else if (cmd.write && sel) begin
      valid_r <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (cmd.write && sel) begin
      key_r   <= cmd.key;
      count_r <= cmd.count;
    end
  end

  // Match or claim; first hit wins, otherwise the lowest free entry
  always_comb begin
    tok_nxt = tok_i;
    idx_nxt = idx_i;
    if (tok_i.valid && !tok_i.hit) begin
      if (valid_r && key_r == search_key) begin
        tok_nxt.hit   = 1'b1;
        tok_nxt.count = count_r;
        idx_nxt       = MY_IDX;
      end else if (!valid_r && !tok_i.free_seen) begin
        tok_nxt.free_seen = 1'b1;
        tok_nxt.count     = '0;
        idx_nxt           = MY_IDX;
      end
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign tok_o = tok_r;
  assign idx_o = idx_r;

endmodule

/* hw/rtl/per_key_window_rate_governor_core.sv */
// Sequence: the item is captured, its minute is computed and the window rolled; a non-critical
//   admit or an in-window release then runs the key search (it walks the cell chain one cell a cycle);
//   critical admits, polls and commands that do nothing skip the search and go straight to the result.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (rst_n low, synchronous): window, table valid bits, statistics cleared;
//   limits return to 120 global and 30 per key.
module per_key_window_rate_governor_core
  import pkwrg_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CNT_W-1:0]  cfg_data,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SEC_W-1:0]  in_now_seconds,
  input  logic [KEY_W-1:0]  in_rule_key,
  input  logic              in_critical,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_allow,
  output logic              out_summary_flag,
  output logic [STAT_W-1:0] out_summary_count,
  output logic              out_released,
  output logic [STAT_W-1:0] out_admitted_total,
  output logic [STAT_W-1:0] out_suppressed_total,
  output logic [STAT_W-1:0] out_critical_total,
  output logic [STAT_W-1:0] out_summaries_total
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ROLL = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  glim_r, klim_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [SEC_W-1:0]  now_r;
  logic [KEY_W-1:0]  key_r;
  logic              crit_r;
  logic [MIN_W-1:0]  minute_r, minute_nxt;
  logic [2*SEC_W-1:0] prod;

  logic              started_r, started_nxt;
  logic [MIN_W-1:0]  cur_min_r, cur_min_nxt;
  logic [CNT_W-1:0]  gcount_r, gcount_nxt;
  logic [STAT_W-1:0] pending_r, pending_nxt;
  logic [STAT_W-1:0] st_adm_r, st_adm_nxt;
  logic [STAT_W-1:0] st_sup_r, st_sup_nxt;
  logic [STAT_W-1:0] st_crit_r, st_crit_nxt;
  logic [STAT_W-1:0] st_sum_r, st_sum_nxt;
  logic              launch_r, launch_nxt;

  logic              res_allow_r, res_allow_nxt;
  logic              res_emit_r, res_emit_nxt;
  logic [STAT_W-1:0] res_summary_r, res_summary_nxt;
  logic              res_rel_r, res_rel_nxt;

  logic              out_valid_r, out_valid_nxt, out_load;
  logic              o_allow_r, o_emit_r, o_rel_r;
  logic [STAT_W-1:0] o_summary_r, o_adm_r, o_sup_r, o_crit_r, o_sum_r;

  cell_cmd_t         cell_cmd;
  logic [IDX_W-1:0]  wr_idx;
  tok_t              tok_chain [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]  idx_chain [TABLE_ENTRIES+1];

  logic              roll;
  logic              slot_ok;
  logic              over_limit;
  logic [CNT_W-1:0]  glim_eff, klim_eff;

  assign glim_eff = eff_limit(glim_r, GLOBAL_DEFAULT);
  assign klim_eff = eff_limit(klim_r, PER_KEY_DEFAULT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glim_r <= GLOBAL_DEFAULT;
      klim_r <= PER_KEY_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLOBAL_LIMIT:  glim_r <= cfg_data;
        REG_PER_KEY_LIMIT: klim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the item on input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      now_r  <= in_now_seconds;
      key_r  <= in_rule_key;
      crit_r <= in_critical;
    end
  end

  // Minute by reciprocal multiply, registered
  assign prod       = (2*SEC_W)'(now_r) * (2*SEC_W)'(DIV60_MAGIC);
  assign minute_nxt = prod[DIV60_SHIFT +: MIN_W];

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      minute_r <= minute_nxt;
    end
  end

  assign roll = started_r && (minute_r != cur_min_r);

  // Cell chain: the token enters cell 0 in the cycle after the sequencer raises launch
  assign tok_chain[0] = '{valid: launch_r, default: '0};
  assign idx_chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      pkwrg_cell #(
        .IDX   (gi),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cell_cmd),
        .sel        (wr_idx == IDX_W'(gi)),
        .search_key (key_r),
        .tok_i      (tok_chain[gi]),
        .idx_i      (idx_chain[gi]),
        .tok_o      (tok_chain[gi+1]),
        .idx_o      (idx_chain[gi+1])
      );
    end
  endgenerate

  assign wr_idx     = idx_chain[TABLE_ENTRIES];
  assign slot_ok    = tok_chain[TABLE_ENTRIES].hit || tok_chain[TABLE_ENTRIES].free_seen;
  assign over_limit = (gcount_r >= glim_eff) || !slot_ok ||
                      (tok_chain[TABLE_ENTRIES].count >= klim_eff);

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    started_nxt     = started_r;
    cur_min_nxt     = cur_min_r;
    gcount_nxt      = gcount_r;
    pending_nxt     = pending_r;
    st_adm_nxt      = st_adm_r;
    st_sup_nxt      = st_sup_r;
    st_crit_nxt     = st_crit_r;
    st_sum_nxt      = st_sum_r;
    launch_nxt      = 1'b0;
    res_allow_nxt   = res_allow_r;
    res_emit_nxt    = res_emit_r;
    res_summary_nxt = res_summary_r;
    res_rel_nxt     = res_rel_r;
    out_load        = 1'b0;
    cell_cmd        = '0;
    cell_cmd.key    = key_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_allow_nxt   = 1'b0;
          res_emit_nxt    = 1'b0;
          res_summary_nxt = '0;
          res_rel_nxt     = 1'b0;
          state_nxt       = ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_ROLL;
      end
      ST_ROLL: begin
        // Roll the window where the command calls for it
        if ((cmd_r == CMD_ADMIT || cmd_r == CMD_POLL) && roll) begin
          cell_cmd.clear  = 1'b1;
          pending_nxt     = '0;
          cur_min_nxt     = minute_r;
          gcount_nxt      = (pending_r != '0) ? CNT_W'(1) : '0;
          res_summary_nxt = pending_r;
          res_emit_nxt    = (pending_r != '0);
          if (pending_r != '0) begin
            st_sum_nxt = sat_inc(st_sum_r);
          end
        end
        state_nxt = ST_FIN;
        unique case (cmd_r)
          CMD_ADMIT: begin
            if (!started_r) begin
              started_nxt = 1'b1;
              cur_min_nxt = minute_r;
            end
            if (crit_r) begin
              res_allow_nxt = 1'b1;
              st_adm_nxt    = sat_inc(st_adm_r);
              st_crit_nxt   = sat_inc(st_crit_r);
            end else begin
              launch_nxt = 1'b1;
              state_nxt  = ST_SCAN;
            end
          end
          CMD_RELEASE: begin
            if (started_r && !crit_r && minute_r == cur_min_r) begin
              launch_nxt = 1'b1;
              state_nxt  = ST_SCAN;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        // Apply the search result once the token leaves the last cell
        if (tok_chain[TABLE_ENTRIES].valid) begin
          state_nxt      = ST_FIN;
          cell_cmd.write = slot_ok;
          cell_cmd.count = tok_chain[TABLE_ENTRIES].count;
          if (cmd_r == CMD_ADMIT) begin
            if (over_limit) begin
              pending_nxt = sat_inc(pending_r);
              st_sup_nxt  = sat_inc(st_sup_r);
            end else begin
              gcount_nxt     = gcount_r + CNT_W'(1);
              cell_cmd.count = tok_chain[TABLE_ENTRIES].count + CNT_W'(1);
              st_adm_nxt     = sat_inc(st_adm_r);
              res_allow_nxt  = 1'b1;
            end
          end else begin
            if (gcount_r != '0) begin
              gcount_nxt = gcount_r - CNT_W'(1);
            end
            if (tok_chain[TABLE_ENTRIES].count != '0) begin
              cell_cmd.count = tok_chain[TABLE_ENTRIES].count - CNT_W'(1);
            end
            res_rel_nxt = 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load a finished result, drop it on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      cur_min_r   <= '0;
      gcount_r    <= '0;
      pending_r   <= '0;
      st_adm_r    <= '0;
      st_sup_r    <= '0;
      st_crit_r   <= '0;
      st_sum_r    <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      cur_min_r   <= cur_min_nxt;
      gcount_r    <= gcount_nxt;
      pending_r   <= pending_nxt;
      st_adm_r    <= st_adm_nxt;
      st_sup_r    <= st_sup_nxt;
      st_crit_r   <= st_crit_nxt;
      st_sum_r    <= st_sum_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_allow_r   <= res_allow_nxt;
    res_emit_r    <= res_emit_nxt;
    res_summary_r <= res_summary_nxt;
    res_rel_r     <= res_rel_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_allow_r   <= res_allow_r;
      o_emit_r    <= res_emit_r;
      o_summary_r <= res_summary_r;
      o_rel_r     <= res_rel_r;
      o_adm_r     <= st_adm_r;
      o_sup_r     <= st_sup_r;
      o_crit_r    <= st_crit_r;
      o_sum_r     <= st_sum_r;
    end
  end

  assign in_ready             = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_allow            = o_allow_r;
  assign out_summary_flag     = o_emit_r;
  assign out_summary_count    = o_summary_r;
  assign out_released         = o_rel_r;
  assign out_admitted_total   = o_adm_r;
  assign out_suppressed_total = o_sup_r;
  assign out_critical_total   = o_crit_r;
  assign out_summaries_total  = o_sum_r;

endmodule

/* hw/rtl/pkwrg_checker.sv */
module pkwrg_checker
  import pkwrg_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_allow,
  input logic              out_summary_flag,
  input logic [STAT_W-1:0] out_summary_count,
  input logic              out_released
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_summary_count))
    else $error("result changed while stalled");

  // Admit and release never report together
  a_allow_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_allow && out_released))
    else $error("allow and released both set");

  // Summary count is nonzero exactly when a summary is flagged
  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_summary_flag == (out_summary_count != '0)))
    else $error("summary flag and count disagree");

  // A summary comes from a rollover and never with a release
  a_sum_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_summary_flag |-> !out_released)
    else $error("summary reported on release");

  // Reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind per_key_window_rate_governor_core pkwrg_checker u_pkwrg_checker (.*);
